FILE: hdl/surf_random_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SURF random generator
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SURF_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define SURF_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define SRG_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define SRG_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hdl/srg_pkg.sv
// ----------------------------------------------------------------------------
// SURF random generator package
// Shared constants, unit handshake structs and the mush rotation function.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned SeedDepth   = 32;
  localparam int unsigned InputDepth  = 12;
  localparam int unsigned OutputDepth = 8;
  localparam int unsigned Rounds      = 16;

  localparam logic [31:0] GOLDEN = 32'h9e37_79b9;

  // Item commands
  localparam logic [1:0] CMD_SEED  = 2'd0;
  localparam logic [1:0] CMD_INPUT = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  // Control and status between the sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Rotate left by 5, 7, 9 or 13 bits, chosen by the low bits of the word index
  function automatic logic [31:0] mush_rot(input logic [31:0] x, input logic [1:0] sel);
    logic [31:0] r;
    case (sel)
      2'd0: r = {x[26:0], x[31:27]};
      2'd1: r = {x[24:0], x[31:25]};
      2'd2: r = {x[22:0], x[31:23]};
      2'd3: r = {x[18:0], x[31:19]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/srg_mod.sv
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module srg_mod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srg_pkg::unit_ctl_t    ctl_i,
  input  logic [31:0]           dividend_i,
  input  logic [31:0]           divisor_i,
  output srg_pkg::unit_sts_t    sts_o,
  output logic [31:0]           rem_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] div_q, div_d;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        last;

  // Shift in the next dividend bit and subtract when it fits
  assign shifted = {rem_q, dvd_q[31]};
  assign diff    = shifted - {1'b0, div_q};
  assign last    = busy_q && (cnt_q == 5'd31);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (ctl_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      rem_d  = 32'd0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = (shifted >= {1'b0, div_q}) ? diff[31:0] : shifted[31:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = last;
  assign rem_o      = rem_q;

endmodule

FILE: hdl/srg_refill.sv
// ----------------------------------------------------------------------------
// SURF refill engine
// Holds seed, input and output words; on start bumps the 128-bit counter and
// runs 2 passes of 16 rounds through one shared mush step per cycle.
// ----------------------------------------------------------------------------
module srg_refill (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srg_pkg::unit_ctl_t    ctl_i,
  output srg_pkg::unit_sts_t    sts_o,
  input  logic                  seed_we_i,
  input  logic                  input_we_i,
  input  logic [4:0]            wr_index_i,
  input  logic [31:0]           wr_value_i,
  input  logic [2:0]            rd_index_i,
  output logic [31:0]           rd_word_o
);

  typedef enum logic [4:0] {
    R_IDLE = 5'b00001,
    R_INC  = 5'b00010,
    R_INIT = 5'b00100,
    R_MUSH = 5'b01000,
    R_MIX  = 5'b10000
  } rstate_e;

  rstate_e     state_q, state_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  round_q, round_d;
  logic        pass_q, pass_d;
  logic        carry_q, carry_d;

  logic [31:0] seed_q [srg_pkg::SeedDepth];
  logic [31:0] inw_q  [srg_pkg::InputDepth];
  logic [31:0] obuf_q [srg_pkg::OutputDepth];
  logic [31:0] t_q    [srg_pkg::InputDepth];
  logic [31:0] x_q, x_d;
  logic [31:0] sum_q, sum_d;

  logic [4:0]  seed_addr;
  logic [31:0] seed_rd;
  logic [31:0] t_rd;
  logic [31:0] inc_word;
  logic [31:0] init_word;
  logic [31:0] mush_m;
  logic [31:0] mush_t;
  logic        step_last;

  // Single seed read port: upper input half during init, round keys during mush
  assign seed_addr = (state_q == R_INIT) ? ({1'b0, idx_q} + 5'd12) : {1'b0, idx_q};
  assign seed_rd   = seed_q[seed_addr];
  assign t_rd      = t_q[idx_q];

  assign inc_word  = inw_q[idx_q] + {31'd0, carry_q};
  assign init_word = inw_q[idx_q] ^ seed_rd;

  // Shared mush step
  assign mush_m = ((x_q ^ seed_rd) + sum_q) ^ srg_pkg::mush_rot(x_q, idx_q[1:0]);
  assign mush_t = t_rd + mush_m;

  assign step_last = (idx_q == 4'(srg_pkg::InputDepth - 1));

  // Sequence the refill
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    round_d = round_q;
    pass_d  = pass_q;
    carry_d = carry_q;
    x_d     = x_q;
    sum_d   = sum_q;
    case (state_q)
      R_IDLE: begin
        if (ctl_i.start) begin
          state_d = R_INC;
          idx_d   = 4'd0;
          carry_d = 1'b1;
        end
      end
      R_INC: begin
        carry_d = carry_q && (inc_word == 32'd0);
        if (idx_q == 4'd3) begin
          state_d = R_INIT;
          idx_d   = 4'd0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      R_INIT: begin
        if (step_last) begin
          x_d     = init_word;
          sum_d   = srg_pkg::GOLDEN;
          idx_d   = 4'd0;
          round_d = 4'd0;
          pass_d  = 1'b0;
          state_d = R_MUSH;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      R_MUSH: begin
        x_d = mush_t;
        if (step_last) begin
          idx_d = 4'd0;
          sum_d = sum_q + srg_pkg::GOLDEN;
          if (round_q == 4'(srg_pkg::Rounds - 1)) begin
            round_d = 4'd0;
            state_d = R_MIX;
          end else begin
            round_d = round_q + 4'd1;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      R_MIX: begin
        if (pass_q) begin
          state_d = R_IDLE;
        end else begin
          pass_d  = 1'b1;
          state_d = R_MUSH;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      idx_q   <= 4'd0;
      round_q <= 4'd0;
      pass_q  <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      round_q <= round_d;
      pass_q  <= pass_d;
      carry_q <= carry_d;
    end
  end

  // Working words of the mush
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    sum_q <= sum_d;
    if (state_q == R_INIT) begin
      t_q[idx_q] <= init_word;
    end else if (state_q == R_MUSH) begin
      t_q[idx_q] <= mush_t;
    end
  end

  // Seed words: written by items only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srg_pkg::SeedDepth; i++) begin
        seed_q[i] <= 32'd0;
      end
    end else if (seed_we_i) begin
      seed_q[wr_index_i] <= wr_value_i;
    end
  end

  // Input words: written by items, counter words bumped on refill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srg_pkg::InputDepth; i++) begin
        inw_q[i] <= 32'd0;
      end
    end else if (input_we_i && (wr_index_i < 5'(srg_pkg::InputDepth))) begin
      inw_q[wr_index_i[3:0]] <= wr_value_i;
    end else if (state_q == R_INC) begin
      inw_q[idx_q] <= inc_word;
    end
  end

  // Output buffer: load from seed at init start, fold in t after each pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < srg_pkg::OutputDepth; j++) begin
        obuf_q[j] <= 32'd0;
      end
    end else if ((state_q == R_INIT) && (idx_q == 4'd0)) begin
      for (int j = 0; j < srg_pkg::OutputDepth; j++) begin
        obuf_q[j] <= seed_q[24 + j];
      end
    end else if (state_q == R_MIX) begin
      for (int j = 0; j < srg_pkg::OutputDepth; j++) begin
        obuf_q[j] <= obuf_q[j] ^ t_q[j + 4];
      end
    end
  end

  assign rd_word_o  = obuf_q[rd_index_i];
  assign sts_o.busy = (state_q != R_IDLE);
  assign sts_o.done = (state_q == R_MIX) && pass_q;

endmodule

FILE: hdl/surf_random_generator_top.sv
// ----------------------------------------------------------------------------
// SURF random generator, top level
// Counter-mode generator: seed and input writes, bounded draws from an
// eight-word buffer that SURF refills when it runs empty.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o   | cmd, word_index, word_value, bound
//  out     | output    | out_valid_o / out_stall_i | random_value
//
//  Writes and ignored items leave the block idle; a zero-bound draw goes straight
//  to hand-off. Any other draw runs accept, buffer read, 32 remainder steps, hand-off.
//  An empty buffer is first refilled (4 counter words, 12 init steps, 2 x 192
//  mush steps on one shared adder path, 2 folds). Reset clears the seed, input
//  and output words and empties the buffer.
//  The result waits in the output register while out_stall_i is high.
// ----------------------------------------------------------------------------
module surf_random_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic [31:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_value_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REFILL = 5'b00010,
    S_LOAD   = 5'b00100,
    S_MOD    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  words_left_q, words_left_d;
  logic [31:0] bound_q, bound_d;
  logic        zero_q, zero_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  logic        in_accept;
  logic        draw;
  logic        out_load;
  logic [3:0]  rd_pos;

  srg_pkg::unit_ctl_t refill_ctl, mod_ctl;
  srg_pkg::unit_sts_t refill_sts, mod_sts;
  logic [31:0]        buf_word;
  logic [31:0]        mod_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign draw       = in_accept && (cmd_i == srg_pkg::CMD_DRAW);
  assign rd_pos     = words_left_q - 4'd1;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign refill_ctl.start = draw && (bound_i != 32'd0) && (words_left_q == 4'd0);
  assign mod_ctl.start    = (state_q == S_LOAD);

  srg_refill u_refill (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (refill_ctl),
    .sts_o      (refill_sts),
    .seed_we_i  (in_accept && (cmd_i == srg_pkg::CMD_SEED)),
    .input_we_i (in_accept && (cmd_i == srg_pkg::CMD_INPUT)),
    .wr_index_i (word_index_i),
    .wr_value_i (word_value_i),
    .rd_index_i (rd_pos[2:0]),
    .rd_word_o  (buf_word)
  );

  srg_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mod_ctl),
    .dividend_i (buf_word),
    .divisor_i  (bound_q),
    .sts_o      (mod_sts),
    .rem_o      (mod_rem)
  );

  // Sequence one draw: refill when empty, take a word, reduce it, hand it off; a zero bound hands off zero
  always_comb begin
    state_d      = state_q;
    words_left_d = words_left_q;
    bound_d      = bound_q;
    zero_d       = zero_q;
    case (state_q)
      S_IDLE: begin
        if (draw) begin
          bound_d = bound_i;
          zero_d  = (bound_i == 32'd0);
          if (bound_i == 32'd0) begin
            state_d = S_DONE;
          end else if (words_left_q == 4'd0) begin
            state_d = S_REFILL;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_REFILL: begin
        if (refill_sts.done) begin
          words_left_d = 4'(srg_pkg::OutputDepth);
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        words_left_d = rd_pos;
        state_d      = S_MOD;
      end
      S_MOD: begin
        if (mod_sts.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = zero_q ? 32'd0 : mod_rem;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      words_left_q <= 4'd0;
      zero_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      words_left_q <= words_left_d;
      zero_q       <= zero_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q    <= bound_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

`include "surf_random_generator_top_assert.svh"

  `SRG_ASSERT_SAME(a_words_left_range, 1'b1, words_left_q <= 4'(srg_pkg::OutputDepth), "words_left out of range")
  `SRG_ASSERT_SAME(a_load_nonempty, state_q == S_LOAD, words_left_q != 4'd0, "buffer read while empty")
  `SRG_ASSERT_SAME(a_refill_owner, refill_sts.busy, state_q == S_REFILL, "refill runs outside refill state")
  `SRG_ASSERT_NEXT(a_mod_done, mod_sts.done, state_q == S_DONE && !mod_sts.busy, "remainder finish not handed off")

endmodule

FILE: sim/tb_surf_random_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the SURF random generator
// Drives seed writes, input writes and bounded draws through the valid/stall
// channel, predicts every drawn value with an in-bench SURF model and checks
// each result in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_surf_random_generator_top;
  import srg_pkg::*;

  // Command code the block ignores
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned DrainCycles = 100;

  // Predicts drawn values and checks them in order of acceptance
  class surf_draw_scoreboard;
    bit [31:0] seed_word[SeedDepth];
    bit [31:0] input_word[InputDepth];
    bit [31:0] out_word[OutputDepth];
    bit [3:0]  words_unread;
    bit [31:0] expected_values[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_seed_writes;
    int unsigned n_input_writes;
    int unsigned n_ignored;
    int unsigned n_refills;

    function bit [31:0] rot_left(bit [31:0] v, bit [1:0] lane);
      int unsigned n;
      case (lane)
        2'd0: n = 5;
        2'd1: n = 7;
        2'd2: n = 9;
        default: n = 13;
      endcase
      return (v << n) | (v >> (32 - n));
    endfunction

    // Advance the 128-bit counter, then run two SURF passes into the buffer
    function void refill_buffer();
      bit [31:0] t[InputDepth];
      bit [31:0] x;
      bit [31:0] acc;
      bit        carry;
      carry = 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (carry) begin
          input_word[k] = input_word[k] + 32'd1;
          carry = (input_word[k] == 32'd0);
        end
      end
      for (int i = 0; i < InputDepth; i++) t[i] = input_word[i] ^ seed_word[12 + i];
      for (int i = 0; i < OutputDepth; i++) out_word[i] = seed_word[24 + i];
      x = t[InputDepth - 1];
      acc = 32'd0;
      for (int p = 0; p < 2; p++) begin
        for (int r = 0; r < Rounds; r++) begin
          acc = acc + GOLDEN;
          for (int i = 0; i < InputDepth; i++) begin
            t[i] = t[i] + (((x ^ seed_word[i]) + acc) ^ rot_left(x, i[1:0]));
            x = t[i];
          end
        end
        for (int i = 0; i < OutputDepth; i++) out_word[i] = out_word[i] ^ t[i + 4];
      end
      words_unread = 4'(OutputDepth);
      n_refills++;
    endfunction

    // Apply one accepted item and queue the value a draw must return
    function void note_item(bit [1:0] c, bit [4:0] idx, bit [31:0] val, bit [31:0] bnd);
      case (c)
        CMD_SEED: begin
          seed_word[idx] = val;
          n_seed_writes++;
        end
        CMD_INPUT: begin
          if (idx < InputDepth) begin
            input_word[idx] = val;
            n_input_writes++;
          end else begin
            n_ignored++;
          end
        end
        CMD_DRAW: begin
          if (bnd == 32'd0) begin
            expected_values.push_back(32'd0);
          end else begin
            if (words_unread == 4'd0) refill_buffer();
            words_unread = words_unread - 4'd1;
            expected_values.push_back(out_word[words_unread[2:0]] % bnd);
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    // Compare one accepted result with the oldest expected value
    function void check_result(bit [31:0] got);
      bit [31:0] want;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected random_value %h, none pending", $time, got);
        n_errors++;
        return;
      end
      want = expected_values.pop_front();
      n_checked++;
      if (got !== want) begin
        $display("%0t: random_value mismatch: expected %h, actual %h", $time, want, got);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_SPARE;
  logic [4:0]  word_index_i = '0;
  logic [31:0] word_value_i = '0;
  logic [31:0] bound_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] random_value_o;

  surf_draw_scoreboard sb;
  int unsigned random_items;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned run_left = 0;
  logic        stall_hold = 1'b0;

  surf_random_generator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .word_index_i   (word_index_i),
    .word_value_i   (word_value_i),
    .bound_i        (bound_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watch both channels; values read here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(random_value_o);
      if (in_valid_i && !in_stall_o) sb.note_item(cmd_i, word_index_i, word_value_i, bound_i);
    end
  end

  // Stall the result channel: free running, light, heavy, or long on/off runs
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(200, 3000);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) != 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 60);
          stall_hold = ~stall_hold;
        end else begin
          run_left--;
        end
        out_stall_i <= stall_hold;
      end
    endcase
  end

  // Present one item and hold it until the block takes it
  task automatic push_item(input logic [1:0] c, input logic [4:0] idx,
                           input logic [31:0] val, input logic [31:0] bnd);
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    word_index_i <= idx;
    word_value_i <= val;
    bound_i      <= bnd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hffff_ffff;
      3: return 32'd1 << $urandom_range(0, 31);
      4: return $urandom_range(2, 16);
      5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Send one random item; mostly draws, some writes, a little noise
  task automatic push_random_item();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 68) begin
      push_item(CMD_DRAW, 5'($urandom), $urandom, pick_bound());
      random_items++;
    end else if (kind < 81) begin
      push_item(CMD_SEED, 5'($urandom_range(0, 31)), pick_word(), $urandom);
      random_items++;
    end else if (kind < 94) begin
      push_item(CMD_INPUT, 5'($urandom_range(0, 11)), pick_word(), $urandom);
      random_items++;
    end else if (kind < 97) begin
      push_item(CMD_INPUT, 5'($urandom_range(12, 31)), $urandom, $urandom);
    end else begin
      push_item(CMD_SPARE, 5'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned burst;
    int unsigned gap;
    sb = new();
    random_items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero bound at reset, ignored items, counter wrap, edge bounds
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'd0);
    push_item(CMD_SPARE, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    for (int k = 0; k < 4; k++) push_item(CMD_INPUT, k[4:0], 32'hffff_ffff, 32'd0);
    push_item(CMD_INPUT, 5'd12, 32'hdead_beef, 32'd0);
    push_item(CMD_INPUT, 5'd31, 32'hffff_ffff, 32'd0);
    push_item(CMD_INPUT, 5'd11, 32'h0000_0000, 32'd0);
    push_item(CMD_SEED, 5'd0, 32'hffff_ffff, 32'd0);
    push_item(CMD_SEED, 5'd31, 32'hffff_ffff, 32'd0);
    push_item(CMD_SEED, 5'd12, 32'h0000_0001, 32'd0);
    push_item(CMD_SEED, 5'd24, 32'h8000_0000, 32'd0);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'hffff_ffff);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'd1);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'h8000_0000);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'd0);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'd7);
    repeat (4) push_item(CMD_DRAW, 5'd0, 32'd0, $urandom);
    push_item(CMD_DRAW, 5'd0, 32'd0, 32'd3);
    push_item(CMD_SEED, 5'd0, 32'h0000_0000, 32'd0);
    push_item(CMD_DRAW, 5'd0, 32'd0, $urandom);

    // Random: bursts of items with gaps, sometimes back to back
    while (random_items < RandomItems) begin
      burst = $urandom_range(1, 24);
      repeat (burst) push_random_item();
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(9, 120);
      else gap = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding draws, then let the block settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d draws checked, %0d refills, %0d seed writes, %0d input writes,",
             sb.n_checked, sb.n_refills, sb.n_seed_writes, sb.n_input_writes);
    $display("and %0d ignored items; %0d mismatches seen.", sb.n_ignored, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("Timeout with %0d draws still pending", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: surf_random_generator_top.f
+incdir+hdl
hdl/srg_pkg.sv
hdl/srg_mod.sv
hdl/srg_refill.sv
hdl/surf_random_generator_top.sv
sim/tb_surf_random_generator_top.sv
